@@ rtl/pzsc_pkg.sv @@
package pzsc_pkg;

  // item kinds carried on s_tuser
  localparam logic ACT_SAMPLE = 1'b0;
  localparam logic ACT_WRITE  = 1'b1;

  // width of the section index field of a settings item
  localparam int SEC_FIELD_BITS = 3;

endpackage

@@ rtl/pole_zero_section_cascade.sv @@
// cascade of up to SECTIONS conjugate-pair sections, each a zero pair (fir) or a pole
// pair (iir), run one after another on every sample item. the input stream carries two
// kinds of item, told apart by s_tuser: a sample item (Q1.23 by default) that gives one
// filtered sample on the output stream, and a settings item that sets one section's
// type, enable, gain and coefficients (Q4.20 by default) and gives nothing back.
// enabling a disabled section, or changing a section's type, clears its two delay words.
// one shared signed multiplier does all the work under a small sequencer: a sample
// item keeps the block busy after it is accepted while the sequencer scans every
// section in index order, and each enabled one also runs its three products (gain,
// first and second coefficient) and the final sum. a settings item is done in the
// cycle it is accepted. a finished sample sits in the output register, so the next
// item is taken while it waits.
module pole_zero_section_cascade #(
  parameter int SECTIONS    = 8,
  parameter int SAMPLE_BITS = 24,
  parameter int COEF_BITS   = 24
) (
  input  logic clk,
  input  logic rst,
  // input items
  input  logic s_tvalid,
  output logic s_tready,
  // section[2:0], sample_in, is_pole, enable, gain_value, coef_a, coef_b, zero fill
  input  logic [((pzsc_pkg::SEC_FIELD_BITS + SAMPLE_BITS + 2 + 3 * COEF_BITS + 7) / 8) * 8
                - 1:0] s_tdata,
  // action
  input  logic s_tuser,
  // result items
  output logic m_tvalid,
  input  logic m_tready,
  // sample_out, zero fill
  output logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0] m_tdata
);
  import pzsc_pkg::*;

  localparam int SEC_FIELD_W = pzsc_pkg::SEC_FIELD_BITS;

  // input packing, lowest field first
  localparam int OFF_SEC  = 0;
  localparam int OFF_SMP  = OFF_SEC + SEC_FIELD_W;
  localparam int OFF_POLE = OFF_SMP + SAMPLE_BITS;
  localparam int OFF_EN   = OFF_POLE + 1;
  localparam int OFF_GAIN = OFF_EN + 1;
  localparam int OFF_A    = OFF_GAIN + COEF_BITS;
  localparam int OFF_B    = OFF_A + COEF_BITS;
  localparam int OUT_W    = ((SAMPLE_BITS + 7) / 8) * 8;

  localparam int IDX_W  = (SECTIONS > 1) ? $clog2(SECTIONS) : 1;
  localparam int FRAC_W = COEF_BITS - 4;
  localparam int PROD_W = COEF_BITS + SAMPLE_BITS;
  // three terms of up to SAMPLE_BITS + 4 bits each
  localparam int ACC_W  = SAMPLE_BITS + 6;

  localparam logic signed [PROD_W-1:0] RND_HALF = PROD_W'(1) <<< (FRAC_W - 1);
  localparam logic signed [SAMPLE_BITS-1:0] SMP_HI = {1'b0, {(SAMPLE_BITS - 1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] SMP_LO = {1'b1, {(SAMPLE_BITS - 1){1'b0}}};

  typedef enum logic [2:0] {
    IDLE,   // waiting for an item
    SCAN,   // look at section k, read its words
    MUL_G,  // gain times cascade value
    MUL_A,  // first coefficient times first delay
    MUL_B,  // second coefficient times second delay
    SUM,    // close the sum, update the delay line
    DONE    // hand the sample to the output register
  } state_t;

  state_t state;

  // fields of the incoming item
  logic [SEC_FIELD_W-1:0]        s_section;
  logic signed [SAMPLE_BITS-1:0] s_sample;
  logic                          s_is_pole;
  logic                          s_enable;
  logic signed [COEF_BITS-1:0]   s_gain;
  logic signed [COEF_BITS-1:0]   s_coef_a;
  logic signed [COEF_BITS-1:0]   s_coef_b;

  assign s_section = s_tdata[OFF_SEC +: SEC_FIELD_W];
  assign s_sample  = s_tdata[OFF_SMP +: SAMPLE_BITS];
  assign s_is_pole = s_tdata[OFF_POLE];
  assign s_enable  = s_tdata[OFF_EN];
  assign s_gain    = s_tdata[OFF_GAIN +: COEF_BITS];
  assign s_coef_a  = s_tdata[OFF_A +: COEF_BITS];
  assign s_coef_b  = s_tdata[OFF_B +: COEF_BITS];

  // per-section control bits live in flops, coefficients and delays in memories.
  // memories need no reset: a section is only run after a write enabled it, and
  // that write set its coefficients and cleared its delays
  logic [SECTIONS-1:0] sec_pole;
  logic [SECTIONS-1:0] sec_enabled;

  logic [3*COEF_BITS-1:0]   coef_mem [SECTIONS];   // b, a, gain from the top down
  logic [2*SAMPLE_BITS-1:0] dly_mem  [SECTIONS];   // d2, d1 from the top down
  logic [3*COEF_BITS-1:0]   rd_coef;
  logic [2*SAMPLE_BITS-1:0] rd_dly;

  logic [IDX_W-1:0] k;
  logic             k_last;
  logic [IDX_W-1:0] wr_idx;
  logic             wr_ok;
  logic             accept;
  logic             wr_item;
  logic             clear_dly;
  logic             out_load;

  logic signed [COEF_BITS-1:0]   cur_gain, cur_a, cur_b;
  logic signed [SAMPLE_BITS-1:0] cur_d1, cur_d2;

  logic signed [COEF_BITS-1:0]   mul_c;
  logic signed [SAMPLE_BITS-1:0] mul_s;
  logic signed [PROD_W-1:0]      prod;
  logic signed [ACC_W-1:0]       term;
  logic signed [ACC_W-1:0]       acc;
  logic signed [ACC_W-1:0]       sum_next;
  logic signed [SAMPLE_BITS-1:0] v_now, y_now;
  logic signed [SAMPLE_BITS-1:0] v_reg;
  logic signed [SAMPLE_BITS-1:0] x;        // value running down the cascade
  logic signed [SAMPLE_BITS-1:0] y_out;

  logic                     dly_we;
  logic [IDX_W-1:0]         dly_addr;
  logic [2*SAMPLE_BITS-1:0] dly_wdata;

  // product back to sample scale, rounded half up
  function automatic logic signed [ACC_W-1:0] rnd(input logic signed [PROD_W-1:0] p);
    logic signed [PROD_W-1:0] t;
    t = (p + RND_HALF) >>> FRAC_W;
    return ACC_W'(t);
  endfunction

  // clamp to the sample range
  function automatic logic signed [SAMPLE_BITS-1:0] sat(input logic signed [ACC_W-1:0] v);
    logic signed [SAMPLE_BITS-1:0] r;
    if (v[ACC_W-1:SAMPLE_BITS-1] == {(ACC_W - SAMPLE_BITS + 1){v[ACC_W-1]}}) begin
      r = v[SAMPLE_BITS-1:0];
    end else if (v[ACC_W-1]) begin
      r = SMP_LO;
    end else begin
      r = SMP_HI;
    end
    return r;
  endfunction

  assign s_tready = (state == IDLE);
  assign accept   = s_tvalid && s_tready;
  assign wr_item  = accept && (s_tuser == ACT_WRITE);
  assign wr_idx   = IDX_W'(s_section);
  assign wr_ok    = (32'(s_section) < SECTIONS);
  assign k_last   = (k == IDX_W'(SECTIONS - 1));
  assign out_load = (state == DONE) && (!m_tvalid || m_tready);

  // activation or a change of type starts the section from silence
  assign clear_dly = (s_enable && !sec_enabled[wr_idx]) || (s_is_pole != sec_pole[wr_idx]);

  assign cur_gain = rd_coef[0 +: COEF_BITS];
  assign cur_a    = rd_coef[COEF_BITS +: COEF_BITS];
  assign cur_b    = rd_coef[2*COEF_BITS +: COEF_BITS];
  assign cur_d1   = rd_dly[0 +: SAMPLE_BITS];
  assign cur_d2   = rd_dly[SAMPLE_BITS +: SAMPLE_BITS];

  // operand select for the shared multiplier
  always_comb begin
    unique case (state)
      MUL_A: begin
        mul_c = cur_a;
        mul_s = cur_d1;
      end
      MUL_B: begin
        mul_c = cur_b;
        mul_s = cur_d2;
      end
      default: begin
        mul_c = cur_gain;
        mul_s = x;
      end
    endcase
  end

  // prod holds the product issued in the previous state
  assign term     = rnd(prod);
  assign v_now    = sat(term);
  assign sum_next = sec_pole[k] ? (acc - term) : (acc + term);
  assign y_now    = sat(sum_next);

  // one delay memory write port: clear on activation or type change, shift on a sum
  always_comb begin
    if (state == SUM) begin
      dly_we    = 1'b1;
      dly_addr  = k;
      dly_wdata = {cur_d1, (sec_pole[k] ? y_now : v_reg)};
    end else begin
      dly_we    = wr_item && wr_ok && clear_dly;
      dly_addr  = wr_idx;
      dly_wdata = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_item && wr_ok) begin
      coef_mem[wr_idx] <= {s_coef_b, s_coef_a, s_gain};
    end
    if (dly_we) begin
      dly_mem[dly_addr] <= dly_wdata;
    end
    if (state == SCAN) begin
      rd_coef <= coef_mem[k];
      rd_dly  <= dly_mem[k];
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    prod <= PROD_W'(mul_c) * PROD_W'(mul_s);
    if (accept) begin
      x <= s_sample;
    end
    if (state == MUL_A) begin
      v_reg <= v_now;
      acc   <= ACC_W'(v_now);
    end
    if (state == MUL_B) begin
      acc <= sum_next;
    end
    if (state == SUM) begin
      x <= y_now;
    end
  end

  // sequencer, section control bits and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= IDLE;
      k           <= '0;
      sec_pole    <= '0;
      sec_enabled <= '0;
      m_tvalid    <= 1'b0;
    end else begin
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        IDLE: begin
          if (accept) begin
            if (s_tuser == ACT_WRITE) begin
              if (wr_ok) begin
                sec_pole[wr_idx]    <= s_is_pole;
                sec_enabled[wr_idx] <= s_enable;
              end
            end else begin
              k     <= '0;
              state <= SCAN;
            end
          end
        end
        SCAN: begin
          if (sec_enabled[k]) begin
            state <= MUL_G;
          end else if (k_last) begin
            state <= DONE;
          end else begin
            k <= k + 1'b1;
          end
        end
        MUL_G: state <= MUL_A;
        MUL_A: state <= MUL_B;
        MUL_B: state <= SUM;
        SUM: begin
          if (k_last) begin
            state <= DONE;
          end else begin
            k     <= k + 1'b1;
            state <= SCAN;
          end
        end
        DONE: begin
          // wait while an earlier sample still sits in the output register
          if (out_load) begin
            y_out <= x;
            state <= IDLE;
          end
        end
        default: state <= IDLE;
      endcase
    end
  end

  assign m_tdata = OUT_W'($unsigned(y_out));

endmodule

@@ rtl/pzsc_checker.sv @@
module pzsc_checker #(
  parameter int SAMPLE_BITS = 24
) (
  input logic clk,
  input logic rst,
  input logic s_tvalid,
  input logic s_tready,
  input logic s_tuser,
  input logic m_tvalid,
  input logic m_tready,
  input logic [((SAMPLE_BITS + 7) / 8) * 8 - 1:0] m_tdata
);
  import pzsc_pkg::*;

  // a sample item keeps the block busy in the cycle after it is accepted
  a_sample_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tuser == ACT_SAMPLE) |=> !s_tready)
    else $error("ready stayed high after a sample item");

  // a settings item completes in its accept cycle
  a_write_quick: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && (s_tuser == ACT_WRITE) |=> s_tready)
    else $error("block busy after a settings item");

  // a result only appears at the end of sample work
  a_result_after_work: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> $past(!s_tready))
    else $error("result appeared without sample work");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("stalled result changed");

endmodule

bind pole_zero_section_cascade pzsc_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_pzsc_checker (
  .clk(clk),
  .rst(rst),
  .s_tvalid(s_tvalid),
  .s_tready(s_tready),
  .s_tuser(s_tuser),
  .m_tvalid(m_tvalid),
  .m_tready(m_tready),
  .m_tdata(m_tdata)
);

@@ test/pole_zero_section_cascade_checker.sv @@
`timescale 1ns / 100ps

module pole_zero_section_cascade_checker #(
  parameter int SECTIONS    = 8,
  parameter int SAMPLE_BITS = 24,
  parameter int COEF_BITS   = 24,
  parameter int IN_W        = 104,
  parameter int OUT_W       = 24
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_tvalid,
  input  logic            s_tready,
  input  logic [IN_W-1:0] s_tdata,
  input  logic            s_tuser,
  input  logic            m_tvalid,
  input  logic            m_tready,
  input  logic [OUT_W-1:0] m_tdata,
  output int              mismatches,
  output int              pending,
  output int              checked
);
  import pzsc_pkg::*;

  localparam int FRAC = COEF_BITS - 4;
  localparam longint SMP_MAX = (longint'(1) << (SAMPLE_BITS - 1)) - 1;
  localparam longint SMP_MIN = -SMP_MAX - 1;

  // field offsets in s_tdata
  localparam int SMP_LO   = SEC_FIELD_BITS;
  localparam int POLE_BIT = SMP_LO + SAMPLE_BITS;
  localparam int EN_BIT   = POLE_BIT + 1;
  localparam int GAIN_LO  = EN_BIT + 1;
  localparam int A_LO     = GAIN_LO + COEF_BITS;
  localparam int B_LO     = A_LO + COEF_BITS;

  typedef logic signed [SAMPLE_BITS-1:0] sample_t;
  typedef logic signed [COEF_BITS-1:0]   coef_t;

  // shadow copy of the section settings and delay lines
  logic    sec_pole [SECTIONS];
  logic    sec_on   [SECTIONS];
  coef_t   sec_gain [SECTIONS];
  coef_t   sec_a    [SECTIONS];
  coef_t   sec_b    [SECTIONS];
  sample_t dly1     [SECTIONS];
  sample_t dly2     [SECTIONS];

  sample_t filtered_q [$];
  sample_t got, want;
  int      fails, seen, sel;
  logic    pole, en;

  // coefficient times sample back at sample scale, rounded half up
  function automatic longint rescale(input longint c, input longint s);
    return (c * s + (longint'(1) << (FRAC - 1))) >>> FRAC;
  endfunction

  function automatic sample_t clamp(input longint v);
    if (v > SMP_MAX) return sample_t'(SMP_MAX);
    if (v < SMP_MIN) return sample_t'(SMP_MIN);
    return sample_t'(v);
  endfunction

  // run one sample through every enabled section in index order
  function automatic sample_t cascade_sample(input sample_t x_in);
    longint  x, v, ta, tb;
    sample_t y;
    x = longint'(x_in);
    for (int s = 0; s < SECTIONS; s++) begin
      if (sec_on[s]) begin
        v  = longint'(clamp(rescale(longint'(sec_gain[s]), x)));
        ta = rescale(longint'(sec_a[s]), longint'(dly1[s]));
        tb = rescale(longint'(sec_b[s]), longint'(dly2[s]));
        dly2[s] = dly1[s];
        if (sec_pole[s]) begin
          y = clamp(v - ta - tb);
          dly1[s] = y;
        end else begin
          y = clamp(v + ta + tb);
          dly1[s] = sample_t'(v);
        end
        x = longint'(y);
      end
    end
    return sample_t'(x);
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      for (int s = 0; s < SECTIONS; s++) begin
        sec_pole[s] = 1'b0;
        sec_on[s]   = 1'b0;
        sec_gain[s] = coef_t'(longint'(1) << FRAC);
        sec_a[s]    = '0;
        sec_b[s]    = '0;
        dly1[s]     = '0;
        dly2[s]     = '0;
      end
      filtered_q.delete();
      fails = 0;
      seen  = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        got = m_tdata[SAMPLE_BITS-1:0];
        seen++;
        if (filtered_q.size() == 0) begin
          fails++;
          if (fails <= 10)
            $display("%0t: unexpected output sample %0d, none pending", $realtime, got);
        end else begin
          want = filtered_q.pop_front();
          if (got !== want) begin
            fails++;
            if (fails <= 10)
              $display("%0t: output sample %0d: expected %0d, got %0d",
                       $realtime, seen, want, got);
          end
        end
      end
      if (s_tvalid && s_tready) begin
        if (s_tuser == ACT_WRITE) begin
          sel  = int'(s_tdata[SEC_FIELD_BITS-1:0]);
          pole = s_tdata[POLE_BIT];
          en   = s_tdata[EN_BIT];
          if (sel < SECTIONS) begin
            // activation or a type change starts the section from silence
            if ((en && !sec_on[sel]) || pole != sec_pole[sel]) begin
              dly1[sel] = '0;
              dly2[sel] = '0;
            end
            sec_pole[sel] = pole;
            sec_on[sel]   = en;
            sec_gain[sel] = s_tdata[GAIN_LO +: COEF_BITS];
            sec_a[sel]    = s_tdata[A_LO +: COEF_BITS];
            sec_b[sel]    = s_tdata[B_LO +: COEF_BITS];
          end
        end else begin
          filtered_q = {filtered_q, cascade_sample(s_tdata[SMP_LO +: SAMPLE_BITS])};
        end
      end
    end
    mismatches <= fails;
    pending    <= filtered_q.size();
    checked    <= seen;
  end

endmodule

@@ test/pole_zero_section_cascade_tb.sv @@
`timescale 1ns / 100ps

module pole_zero_section_cascade_tb;
  import pzsc_pkg::*;

  localparam int SAMPLE_BITS = 24;
  localparam int COEF_BITS   = 24;
  localparam int IN_W  = ((SEC_FIELD_BITS + SAMPLE_BITS + 2 + 3 * COEF_BITS + 7) / 8) * 8;
  localparam int OUT_W = ((SAMPLE_BITS + 7) / 8) * 8;

  // field offsets in s_tdata, lowest first
  localparam int SMP_LO   = SEC_FIELD_BITS;
  localparam int POLE_BIT = SMP_LO + SAMPLE_BITS;
  localparam int EN_BIT   = POLE_BIT + 1;
  localparam int GAIN_LO  = EN_BIT + 1;
  localparam int A_LO     = GAIN_LO + COEF_BITS;
  localparam int B_LO     = A_LO + COEF_BITS;

  // handy Q4.20 and Q1.23 values
  localparam logic [23:0] UNITY  = 24'h100000;
  localparam logic [23:0] HALF_Q = 24'h080000;
  localparam logic [23:0] POS_FS = 24'h7fffff;
  localparam logic [23:0] NEG_FS = 24'h800000;

  localparam int RANDOM_ITEMS = 1100;
  localparam int CALM_ITEMS   = 150;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             s_tvalid = 1'b0;
  logic             s_tready;
  // section, sample_in, is_pole, enable, gain_value, coef_a, coef_b, zero fill
  logic [IN_W-1:0]  s_tdata = '0;
  // action
  logic             s_tuser = ACT_SAMPLE;
  logic             m_tvalid;
  logic             m_tready = 1'b0;
  // sample_out
  logic [OUT_W-1:0] m_tdata;

  int mismatches, pending, checked;

  // idling control: bursts only while idle_on, none in the calm tail
  bit idle_on = 1'b1;
  bit calm    = 1'b0;
  int stall_left = 0;
  int n_samples  = 0;
  int n_writes   = 0;

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  pole_zero_section_cascade uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  pole_zero_section_cascade_checker #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .COEF_BITS   (COEF_BITS),
    .IN_W        (IN_W),
    .OUT_W       (OUT_W)
  ) watch (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .mismatches (mismatches),
    .pending    (pending),
    .checked    (checked)
  );

  // output side back-pressure in random bursts
  always @(posedge clk) begin
    if (stall_left > 0) begin
      m_tready   <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!rst && idle_on && !calm && $urandom_range(0, 99) < 10) begin
      m_tready   <= 1'b0;
      stall_left <= $urandom_range(1, 18) - 1;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // drive one item and hold it until it is taken, then maybe pause
  task automatic put_item(input logic act, input logic [2:0] sec, input logic [23:0] smp,
                          input logic pole, input logic en, input logic [23:0] gain,
                          input logic [23:0] ca, input logic [23:0] cb);
    logic [IN_W-1:0] word;
    word = '0;
    word[SEC_FIELD_BITS-1:0]  = sec;
    word[SMP_LO +: 24]        = smp;
    word[POLE_BIT]            = pole;
    word[EN_BIT]              = en;
    word[GAIN_LO +: 24]       = gain;
    word[A_LO +: 24]          = ca;
    word[B_LO +: 24]          = cb;
    s_tdata  <= word;
    s_tuser  <= act;
    s_tvalid <= 1'b1;
    do @(posedge clk); while (!s_tready);
    if (act == ACT_WRITE) n_writes++;
    else n_samples++;
    if (idle_on && !calm && $urandom_range(0, 99) < 15) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 18)) @(posedge clk);
    end
  endtask

  // coefficient mostly in a well-behaved range, sometimes any pattern or an extreme
  function automatic logic [23:0] pick_coef(input bit second);
    int r;
    r = $urandom_range(0, 99);
    if (r < 15) return 24'($urandom);
    if (r < 22) return $urandom_range(0, 1) ? POS_FS : NEG_FS;
    // second coefficient is a squared radius below one, first within plus or minus two
    if (second) return 24'($urandom_range(0, 1030000));
    return 24'($urandom_range(0, 1 << 22) - (1 << 21));
  endfunction

  initial begin
    logic [23:0] gain;
    int          r;

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // nothing enabled: samples pass straight through, junk in unused fields
    put_item(ACT_SAMPLE, 3'($urandom), POS_FS, 1'b1, 1'b1, 24'($urandom), 24'($urandom),
             24'($urandom));
    put_item(ACT_SAMPLE, 3'($urandom), NEG_FS, 1'b0, 1'b1, 24'($urandom), 24'($urandom),
             24'($urandom));
    put_item(ACT_SAMPLE, 3'd0, 24'd0, 1'b0, 1'b0, 24'd0, 24'd0, 24'd0);

    // one zero section, write carries a junk sample field
    put_item(ACT_WRITE, 3'd0, 24'hffffff, 1'b0, 1'b1, UNITY, UNITY, HALF_Q);
    put_item(ACT_SAMPLE, 3'd7, 24'd1000, 1'b1, 1'b0, POS_FS, NEG_FS, POS_FS);
    put_item(ACT_SAMPLE, 3'd0, -24'sd2000, 1'b0, 1'b0, 24'd0, 24'd0, 24'd0);
    put_item(ACT_SAMPLE, 3'd0, 24'h400000, 1'b0, 1'b0, 24'd0, 24'd0, 24'd0);

    // pole section after it, near the unit circle
    put_item(ACT_WRITE, 3'd3, 24'd0, 1'b1, 1'b1, HALF_Q, -24'sd1572864, 24'd849347);
    put_item(ACT_SAMPLE, 3'd0, POS_FS, 1'b0, 1'b0, 24'd0, 24'd0, 24'd0);
    put_item(ACT_SAMPLE, 3'd0, POS_FS, 1'b0, 1'b0, 24'd0, 24'd0, 24'd0);
    put_item(ACT_SAMPLE, 3'd0, NEG_FS, 1'b0, 1'b0, 24'd0, 24'd0, 24'd0);

    // rewrite an active zero section with the same type: delays are kept, gain saturates
    put_item(ACT_WRITE, 3'd0, 24'd0, 1'b0, 1'b1, POS_FS, NEG_FS, POS_FS);
    put_item(ACT_SAMPLE, 3'd0, 24'd123456, 1'b0, 1'b0, 24'd0, 24'd0, 24'd0);
    put_item(ACT_SAMPLE, 3'd0, 24'hffffff, 1'b0, 1'b0, 24'd0, 24'd0, 24'd0);

    // type change from pole to zero clears the delays
    put_item(ACT_WRITE, 3'd3, 24'd0, 1'b0, 1'b1, UNITY, HALF_Q, HALF_Q);
    put_item(ACT_SAMPLE, 3'd0, 24'd777777, 1'b0, 1'b0, 24'd0, 24'd0, 24'd0);

    // disable then re-enable: activation clears the delays, most negative gain
    put_item(ACT_WRITE, 3'd0, 24'd0, 1'b0, 1'b0, UNITY, UNITY, UNITY);
    put_item(ACT_SAMPLE, 3'd0, 24'd5555, 1'b0, 1'b0, 24'd0, 24'd0, 24'd0);
    put_item(ACT_WRITE, 3'd0, 24'd0, 1'b0, 1'b1, NEG_FS, 24'd0, 24'd0);
    put_item(ACT_SAMPLE, 3'd0, POS_FS, 1'b0, 1'b0, 24'd0, 24'd0, 24'd0);
    put_item(ACT_SAMPLE, 3'd0, NEG_FS, 1'b0, 1'b0, 24'd0, 24'd0, 24'd0);

    // unstable pole section at the last index drives everything into saturation
    put_item(ACT_WRITE, 3'd7, 24'd0, 1'b1, 1'b1, UNITY, POS_FS, NEG_FS);
    repeat (3) put_item(ACT_SAMPLE, 3'd0, 24'h300000, 1'b0, 1'b0, 24'd0, 24'd0, 24'd0);

    // random part: mostly samples, section rewrites now and then
    for (int i = 0; i < RANDOM_ITEMS; i++) begin
      if (i % 60 == 0) idle_on = ($urandom_range(0, 3) != 0);
      calm = (i >= RANDOM_ITEMS - CALM_ITEMS);
      if ($urandom_range(0, 99) < 14) begin
        r = $urandom_range(0, 99);
        if (r < 70) gain = 24'($urandom_range(0, 1 << 21) - (1 << 20));
        else if (r < 85) gain = 24'($urandom);
        else gain = $urandom_range(0, 1) ? POS_FS : NEG_FS;
        put_item(ACT_WRITE, 3'($urandom), 24'($urandom), 1'($urandom_range(0, 1)),
                 ($urandom_range(0, 99) < 65), gain, pick_coef(1'b0), pick_coef(1'b1));
      end else begin
        r = $urandom_range(0, 99);
        put_item(ACT_SAMPLE, 3'($urandom), (r < 8) ? POS_FS : (r < 16) ? NEG_FS :
                 (r < 25) ? 24'($urandom_range(0, 2000) - 1000) : 24'($urandom),
                 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)), 24'($urandom),
                 24'($urandom), 24'($urandom));
      end
    end
    s_tvalid <= 1'b0;

    // drain the output, then leave room for one slow sample to show up
    @(posedge clk);
    while (pending != 0) @(posedge clk);
    repeat (60) @(posedge clk);

    $display("run: %0d sample items and %0d section writes sent, %0d output samples checked",
             n_samples, n_writes, checked);
    $display("run: zero and pole sections, activation and type-change clears, saturation");
    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // hard stop well beyond the slowest legal run
  initial begin
    #12000000;
    $display("timeout waiting for the block");
    $display("FAILED: results differ");
    $finish;
  end

endmodule
